@@ hw/rtl/mbq_pkg.sv @@
// Shared constants and types for the multichannel biquad filter.
package mbq_pkg;

  localparam int CH_W       = 3;
  localparam int DATA_W     = 32;
  localparam int COEF_W     = 16;
  localparam int FRAC_BITS  = 14;
  localparam int NUM_COEFS  = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int PROD_W     = DATA_W + COEF_W;
  localparam int NUM_CHANNELS_DEF = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    COEF_X0 = 3'd0,
    COEF_X1 = 3'd1,
    COEF_X2 = 3'd2,
    COEF_Y1 = 3'd3,
    COEF_Y2 = 3'd4
  } coef_idx_t;

  localparam logic signed [COEF_W-1:0] COEF_RST [NUM_COEFS] = '{
    16'sd1104, 16'sd2210, 16'sd1104, -16'sd18726, 16'sd6763
  };

endpackage

@@ hw/rtl/multichannel_biquad_filter.sv @@
// Multichannel Direct Form I biquad with per-channel history in a memory.
//
// Input transaction: in_tuser carries the channel, in_tdata the signed sample.
// Output transaction: out_tdata carries the filtered sample, one per input,
// in input order. Coefficients (signed Q14) are written through cfg_we /
// cfg_index / cfg_data; the user must write them only while the block is
// idle, as the block itself does not enforce it. Pipeline: the history is
// read at the accepting edge, then products, partial sums and the final
// difference into the output register are registered in turn.
// Throughput: one transaction per cycle for differing channels while the
// output does not stall. A channel whose history is still in the pipeline
// waits until its write-back is done, so a sample of a channel is taken only
// after that channel's last one has passed the history read-modify-write loop.
// Reset clears all history (per-entry valid bits) and loads the default
// low-pass coefficients; the memory is usable in the first cycle after reset.
// When out_tready is low, the output register holds its result and the
// pipeline stages fill up behind it before in_tready drops.
module multichannel_biquad_filter #(
  parameter int NUM_CHANNELS = mbq_pkg::NUM_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mbq_pkg::DATA_W-1:0]    in_tdata,   // [31:0] sample
  input  logic [mbq_pkg::CH_W-1:0]      in_tuser,   // [2:0] channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mbq_pkg::DATA_W-1:0]    out_tdata,  // [31:0] filtered
  input  logic                          cfg_we,
  input  logic [mbq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbq_pkg::COEF_W-1:0]    cfg_data
);

  localparam int DW    = mbq_pkg::DATA_W;
  localparam int CW    = mbq_pkg::CH_W;
  localparam int NC    = mbq_pkg::NUM_COEFS;
  localparam int PW    = mbq_pkg::PROD_W;
  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CHX_W = ((IDX_W > CW) ? IDX_W : CW) + 1;
  localparam int HIST_W = 4 * DW;

  // coefficient registers
  logic signed [mbq_pkg::COEF_W-1:0] coef_r [NC];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NC; k++) coef_r[k] <= mbq_pkg::COEF_RST[k];
    end else if (cfg_we) begin
      case (mbq_pkg::coef_idx_t'(cfg_index))
        mbq_pkg::COEF_X0: coef_r[mbq_pkg::COEF_X0] <= cfg_data;
        mbq_pkg::COEF_X1: coef_r[mbq_pkg::COEF_X1] <= cfg_data;
        mbq_pkg::COEF_X2: coef_r[mbq_pkg::COEF_X2] <= cfg_data;
        mbq_pkg::COEF_Y1: coef_r[mbq_pkg::COEF_Y1] <= cfg_data;
        mbq_pkg::COEF_Y2: coef_r[mbq_pkg::COEF_Y2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline registers
  logic             s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic [CW-1:0]    s1_ch_r, s2_ch_r, s3_ch_r;
  logic             s1_rng_r, s2_rng_r, s3_rng_r;
  logic [IDX_W-1:0] s1_idx_r, s2_idx_r, s3_idx_r;
  logic [DW-1:0]    s1_x0_r, s2_x0_r, s3_x0_r;
  logic [DW-1:0]    s2_x1_r, s3_x1_r, s2_y1_r, s3_y1_r;
  logic [DW-1:0]    s2_p_r [NC];
  logic [DW-1:0]    s3_sa_r, s3_sb_r;
  logic [DW-1:0]    out_data_r;
  logic [HIST_W-1:0] mem_q_r;
  logic             rd_vld_r;

  // history memory: {y2, y1, x2, x1} per channel
  logic [HIST_W-1:0]       hist_mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_r;

  logic [CHX_W-1:0] in_chx;
  logic             in_rng;
  logic [IDX_W-1:0] in_idx;
  logic             go_o, go3, go2, go1, haz, in_acc;
  logic             mem_we;
  logic [DW-1:0]    y0_nxt;
  logic [HIST_W-1:0] wr_data;

  assign in_chx = CHX_W'(in_tuser);
  assign in_rng = in_chx < CHX_W'(NUM_CHANNELS);
  assign in_idx = in_chx[IDX_W-1:0];

  assign go_o = !out_v_r || out_tready;
  assign go3  = !s3_v_r || go_o;
  assign go2  = !s2_v_r || go3;
  assign go1  = !s1_v_r || go2;

  // same channel still in flight: wait for its write-back
  assign haz = in_rng && ((s1_v_r && s1_rng_r && s1_ch_r == in_tuser) ||
                          (s2_v_r && s2_rng_r && s2_ch_r == in_tuser) ||
                          (s3_v_r && s3_rng_r && s3_ch_r == in_tuser));

  assign in_tready = go1 && !haz;
  assign in_acc    = in_tvalid && in_tready;

  assign y0_nxt  = s3_sa_r - s3_sb_r;
  assign mem_we  = s3_v_r && s3_rng_r && go_o;
  assign wr_data = {s3_y1_r, y0_nxt, s3_x1_r, s3_x0_r};

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_q_r  <= hist_mem[in_idx];
      rd_vld_r <= vld_r[in_idx] && in_rng;
    end
    if (mem_we) hist_mem[s3_idx_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[s3_idx_r] <= 1'b1;
    end
  end

  // stage 1: history out of memory, products
  logic [HIST_W-1:0]     hist;
  logic signed [DW-1:0]  mul_a [NC];
  logic signed [PW-1:0]  prod [NC];

  assign hist = rd_vld_r ? mem_q_r : '0;

  always_comb begin
    mul_a[mbq_pkg::COEF_X0] = s1_x0_r;
    mul_a[mbq_pkg::COEF_X1] = hist[DW-1:0];
    mul_a[mbq_pkg::COEF_X2] = hist[2*DW-1:DW];
    mul_a[mbq_pkg::COEF_Y1] = hist[3*DW-1:2*DW];
    mul_a[mbq_pkg::COEF_Y2] = hist[4*DW-1:3*DW];
    for (int k = 0; k < NC; k++) prod[k] = PW'(mul_a[k]) * PW'(coef_r[k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (go1) s1_v_r <= in_acc;
      if (go2) s2_v_r <= s1_v_r;
      if (go3) s3_v_r <= s2_v_r;
      if (go_o) out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ch_r  <= in_tuser;
      s1_rng_r <= in_rng;
      s1_idx_r <= in_idx;
      s1_x0_r  <= in_tdata;
    end
    if (go2) begin
      s2_ch_r  <= s1_ch_r;
      s2_rng_r <= s1_rng_r;
      s2_idx_r <= s1_idx_r;
      s2_x0_r  <= s1_x0_r;
      s2_x1_r  <= hist[DW-1:0];
      s2_y1_r  <= hist[3*DW-1:2*DW];
      for (int k = 0; k < NC; k++) s2_p_r[k] <= prod[k][mbq_pkg::FRAC_BITS +: DW];
    end
    if (go3) begin
      s3_ch_r  <= s2_ch_r;
      s3_rng_r <= s2_rng_r;
      s3_idx_r <= s2_idx_r;
      s3_x0_r  <= s2_x0_r;
      s3_x1_r  <= s2_x1_r;
      s3_y1_r  <= s2_y1_r;
      s3_sa_r  <= s2_p_r[mbq_pkg::COEF_X0] + s2_p_r[mbq_pkg::COEF_X1] +
                  s2_p_r[mbq_pkg::COEF_X2];
      s3_sb_r  <= s2_p_r[mbq_pkg::COEF_Y1] + s2_p_r[mbq_pkg::COEF_Y2];
    end
    if (go_o && s3_v_r) out_data_r <= y0_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // no history read of an entry in the same cycle it is written back
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && in_acc && in_rng && in_idx == s3_idx_r))
    else $error("history read and write-back collide");

  // an accepted transaction always occupies stage 1 next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_v_r)
    else $error("accepted transaction lost at stage 1");

  // write-back only happens while a result moves into the output register
  a_wb_with_out: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> out_v_r)
    else $error("write-back without output result");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule
